FILE: src/knapsack_max_value_table_defines.svh
// Assertion macros for the knapsack value table.
`ifndef KNAPSACK_MAX_VALUE_TABLE_DEFINES_SVH
`define KNAPSACK_MAX_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, checked outside reset.
`define KMVT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("knapsack table assertion failed");
// Next-cycle implication, checked outside reset.
`define KMVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("knapsack table assertion failed");
`else
`define KMVT_ASSERT(lbl, clk, rst_n, prop)
`define KMVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/kmvt_pkg.sv
package kmvt_pkg;

  localparam int unsigned CostWidth   = 13;
  localparam int unsigned ItemWidth   = 16;
  localparam int unsigned ResultWidth = 32;
  localparam int unsigned BudgetWidth = 13;
  localparam logic [BudgetWidth-1:0] BudgetReset = 13'd4096;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RDTOP,
    ST_RESULT
  } kmvt_state_e;

  // sequencer to datapath controls
  typedef struct packed {
    logic clr_we;    // clearing pass writes zero
    logic walk;      // one update step issued this cycle
    logic rd_en;     // table read strobe
    logic res_load;  // move table read data into the output register
  } kmvt_ctrl_t;

endpackage

FILE: src/kmvt_table.sv
module kmvt_table #(
  parameter int unsigned Depth = 4097,
  parameter int unsigned AddrW = 13,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_a_i,
  input  logic [AddrW-1:0] rd_addr_b_i,
  output logic [DataW-1:0] rd_data_a_o,
  output logic [DataW-1:0] rd_data_b_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_a_q;
  logic [DataW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

FILE: src/kmvt_alu.sv
module kmvt_alu #(
  parameter int unsigned AddrW = 13,
  parameter int unsigned DataW = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            walk_i,
  input  logic [AddrW-1:0]                addr_i,
  input  logic [kmvt_pkg::ItemWidth-1:0]  item_value_i,
  input  logic [DataW-1:0]                rd_cur_i,
  input  logic [DataW-1:0]                rd_prev_i,
  output logic                            wr_en_o,
  output logic [AddrW-1:0]                wr_addr_o,
  output logic [DataW-1:0]                wr_data_o
);

  logic             pipe_valid_q;
  logic [AddrW-1:0] pipe_addr_q;
  logic [DataW:0]   sum;
  logic [DataW-1:0] cand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
    end else begin
      pipe_valid_q <= walk_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_addr_q <= addr_i;
  end

  // saturating add, then keep the larger of the two
  assign sum  = {1'b0, rd_prev_i} + (DataW+1)'(item_value_i);
  assign cand = sum[DataW] ? {DataW{1'b1}} : sum[DataW-1:0];

  assign wr_en_o   = pipe_valid_q && (cand > rd_cur_i);
  assign wr_addr_o = pipe_addr_q;
  assign wr_data_o = cand;

endmodule

FILE: src/kmvt_ctrl.sv
module kmvt_ctrl #(
  parameter int unsigned MaxBudget = 4096,
  parameter int unsigned AddrW     = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [kmvt_pkg::BudgetWidth-1:0]  budget_i,
  input  logic                              item_valid_i,
  output logic                              item_ready_o,
  input  logic [kmvt_pkg::CostWidth-1:0]    item_cost_i,
  input  logic [kmvt_pkg::ItemWidth-1:0]    item_value_i,
  input  logic                              last_item_i,
  input  logic                              out_free_i,
  output kmvt_pkg::kmvt_ctrl_t              ctrl_o,
  output logic [AddrW-1:0]                  rd_addr_a_o,
  output logic [AddrW-1:0]                  rd_addr_b_o,
  output logic [AddrW-1:0]                  clr_addr_o,
  output logic [kmvt_pkg::ItemWidth-1:0]    item_value_o
);

  localparam logic [AddrW-1:0] TopAddr = AddrW'(MaxBudget);

  kmvt_pkg::kmvt_state_e state_q, state_d;
  logic [AddrW-1:0] j_q, j_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] cost_q;
  logic [AddrW-1:0] top_q;
  logic [kmvt_pkg::ItemWidth-1:0] val_q;
  logic last_q;
  logic [AddrW-1:0] top_w;
  logic fits;
  logic accept;

  // budget clamps to the table size
  assign top_w  = (32'(budget_i) > 32'(MaxBudget)) ? TopAddr : AddrW'(budget_i);
  assign fits   = 32'(item_cost_i) <= 32'(top_w);
  assign accept = item_valid_i && item_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmvt_pkg::ST_CLEAR: begin
        if (clr_q == TopAddr) begin
          state_d = kmvt_pkg::ST_IDLE;
        end
      end
      kmvt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = fits ? kmvt_pkg::ST_WALK : kmvt_pkg::ST_DRAIN;
        end
      end
      kmvt_pkg::ST_WALK: begin
        if (j_q == cost_q) begin
          state_d = kmvt_pkg::ST_DRAIN;
        end
      end
      kmvt_pkg::ST_DRAIN: begin
        state_d = last_q ? kmvt_pkg::ST_RDTOP : kmvt_pkg::ST_IDLE;
      end
      kmvt_pkg::ST_RDTOP: begin
        state_d = kmvt_pkg::ST_RESULT;
      end
      kmvt_pkg::ST_RESULT: begin
        if (out_free_i) begin
          state_d = kmvt_pkg::ST_CLEAR;
        end
      end
      default: state_d = kmvt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    j_d   = j_q;
    clr_d = clr_q;
    unique case (state_q)
      kmvt_pkg::ST_CLEAR:  clr_d = clr_q + 1'b1;
      kmvt_pkg::ST_IDLE:   j_d   = top_w;
      kmvt_pkg::ST_WALK:   j_d   = j_q - 1'b1;
      kmvt_pkg::ST_RESULT: clr_d = '0;
      default: ;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.clr_we   = (state_q == kmvt_pkg::ST_CLEAR);
    ctrl_o.walk     = (state_q == kmvt_pkg::ST_WALK);
    ctrl_o.rd_en    = (state_q == kmvt_pkg::ST_WALK) || (state_q == kmvt_pkg::ST_RDTOP);
    ctrl_o.res_load = (state_q == kmvt_pkg::ST_RESULT) && out_free_i;
    item_ready_o    = (state_q == kmvt_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmvt_pkg::ST_CLEAR;
      j_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cost_q <= AddrW'(item_cost_i);
      val_q  <= item_value_i;
      last_q <= last_item_i;
      top_q  <= top_w;
    end
  end

  assign rd_addr_a_o  = ctrl_o.walk ? j_q : top_q;
  assign rd_addr_b_o  = j_q - cost_q;
  assign clr_addr_o   = clr_q;
  assign item_value_o = val_q;

endmodule

FILE: src/knapsack_max_value_table.sv
// 0/1 knapsack best-value engine.
// Items come in on the s_axis channel, one transfer per item: cost and value
// in tdata, tlast on the final item of a set. Per item the engine walks the
// budget table from the clamped budget down to the item cost, one entry per
// cycle, through a single saturating add/compare unit on a dual-read table.
// A new item is taken only after the walk and a drain step; when the cost is
// above the budget the item only drains. tready is low while an item runs, and
// the walk, limited by the one table write port, dominates its time.
// On the last item the engine then reads best[budget], loads it into the
// m_axis output register, then clears the table before taking the next item.
// After reset the same clearing pass runs (tready low); the budget register
// resets to 4096 and may be written via cfg at any idle time.
// The output register holds a result until the sink takes it; if the sink
// stalls, the engine waits before its clearing pass, so nothing is dropped.
// A result can sit in the output register while the next set is being fed.
`include "knapsack_max_value_table_defines.svh"

module knapsack_max_value_table #(
  parameter int unsigned MAX_BUDGET  = 4096,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // budget register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i,
  // item input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [12:0] item_cost, [28:13] item_value, rest 0
  input  logic        s_axis_tlast_i,   // last_item
  // result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] best_value
);

  localparam int unsigned Depth = MAX_BUDGET + 1;
  localparam int unsigned AddrW = $clog2(MAX_BUDGET + 1);

  kmvt_pkg::kmvt_ctrl_t ctrl;

  logic [kmvt_pkg::BudgetWidth-1:0] budget_q;
  logic [AddrW-1:0]                 rd_addr_a, rd_addr_b, clr_addr;
  logic [VALUE_WIDTH-1:0]           rd_data_a, rd_data_b;
  logic [kmvt_pkg::ItemWidth-1:0]   item_value;
  logic                             alu_we;
  logic [AddrW-1:0]                 alu_addr;
  logic [VALUE_WIDTH-1:0]           alu_data;
  logic                             tbl_we;
  logic [AddrW-1:0]                 tbl_addr;
  logic [VALUE_WIDTH-1:0]           tbl_data;
  logic                             out_valid_q;
  logic [kmvt_pkg::ResultWidth-1:0] out_data_q;
  logic                             out_free;

  // always writable; the host must change the budget only between items, unchecked
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= kmvt_pkg::BudgetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      budget_q <= cfg_data_i;
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;

  kmvt_ctrl #(
    .MaxBudget (MAX_BUDGET),
    .AddrW     (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .budget_i     (budget_q),
    .item_valid_i (s_axis_tvalid_i),
    .item_ready_o (s_axis_tready_o),
    .item_cost_i  (s_axis_tdata_i[12:0]),
    .item_value_i (s_axis_tdata_i[28:13]),
    .last_item_i  (s_axis_tlast_i),
    .out_free_i   (out_free),
    .ctrl_o       (ctrl),
    .rd_addr_a_o  (rd_addr_a),
    .rd_addr_b_o  (rd_addr_b),
    .clr_addr_o   (clr_addr),
    .item_value_o (item_value)
  );

  // port a reads best[j] (or best[budget] for the result), port b best[j-cost]
  kmvt_table #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (VALUE_WIDTH)
  ) u_table (
    .clk_i       (clk_i),
    .rd_en_i     (ctrl.rd_en),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b),
    .wr_en_i     (tbl_we),
    .wr_addr_i   (tbl_addr),
    .wr_data_i   (tbl_data)
  );

  // one step per cycle; the walk runs downward so best[j-cost] is still
  // the value from before this item when it is read
  kmvt_alu #(
    .AddrW (AddrW),
    .DataW (VALUE_WIDTH)
  ) u_alu (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .walk_i       (ctrl.walk),
    .addr_i       (rd_addr_a),
    .item_value_i (item_value),
    .rd_cur_i     (rd_data_a),
    .rd_prev_i    (rd_data_b),
    .wr_en_o      (alu_we),
    .wr_addr_o    (alu_addr),
    .wr_data_o    (alu_data)
  );

  // write port: clearing pass or update step, never both
  assign tbl_we   = ctrl.clr_we || alu_we;
  assign tbl_addr = ctrl.clr_we ? clr_addr : alu_addr;
  assign tbl_data = ctrl.clr_we ? '0 : alu_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.res_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // wide entries hand over their low 32 bits
  always_ff @(posedge clk_i) begin
    if (ctrl.res_load) begin
      out_data_q <= kmvt_pkg::ResultWidth'(rd_data_a);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `KMVT_ASSERT(a_one_writer, clk_i, rst_ni, !(ctrl.clr_we && alu_we))
  `KMVT_ASSERT(a_no_item_while_update, clk_i, rst_ni, !alu_we || !s_axis_tready_o)
  `KMVT_ASSERT(a_load_into_free_slot, clk_i, rst_ni,
               !ctrl.res_load || !out_valid_q || m_axis_tready_i)
  `KMVT_ASSERT_NEXT(a_clear_after_result, clk_i, rst_ni, ctrl.res_load,
                    ctrl.clr_we && m_axis_tvalid_o)

endmodule
